// File: sv/cobo_pkg.sv
//------------------------------------------------------------------------------
// cobo_pkg
// Shared widths, constants, types and the first-quadrant sine table for the
// circle versus oriented rectangle overlap test.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cobo_pkg;

   localparam int DEF_COORD_BITS     = 13;
   localparam int DEF_TRIG_FRAC_BITS = 16;

   localparam int SIDE_BITS       = 10;
   localparam int HALF_BITS       = SIDE_BITS - 1;
   localparam int RADIUS_BITS     = 10;
   localparam int ANGLE_BITS      = 9;
   localparam int TRIG_IDX_BITS   = 7;

   localparam int DIST_FRAC_SHIFT = 16;
   localparam int RAD_ROOT_BITS   = 18;
   localparam int HH_BITS         = 2 * RAD_ROOT_BITS - DIST_FRAC_SHIFT;
   localparam int RADIUS_SHIFT    = 8;
   localparam int KP1_BITS        = RAD_ROOT_BITS + 1;
   localparam int SAT_BITS        = 41;
   localparam int AREA_BITS       = SAT_BITS + DIST_FRAC_SHIFT;
   localparam logic [63:0] DIST2_SAT = 64'd1 << 40;

   localparam int EXT_BITS        = 12;
   localparam int SUM_SIDE_BITS   = 11;
   localparam int BOUND_BITS      = 20;

   localparam int DLY_DEPTH       = RAD_ROOT_BITS - 6;
   localparam int PIPE_DEPTH      = RAD_ROOT_BITS + 4;

   localparam logic [9:0] DEG_QUARTER    = 10'd90;
   localparam logic [9:0] DEG_HALF_TURN  = 10'd180;
   localparam logic [9:0] DEG_THREE_QTR  = 10'd270;
   localparam logic [9:0] DEG_FULL_TURN  = 10'd360;

   localparam longint unsigned PI_Q30 = 64'd3373259426;

   // Taylor term divisors (2n)*(2n+1) for n = 1 to 12
   localparam longint unsigned TAYLOR_DIV [1:12] = '{
      64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
   };

   typedef struct packed {
      logic [TRIG_IDX_BITS-1:0] idx;
      logic                     neg;
   } quad_type;

   typedef struct packed {
      logic [SAT_BITS-1:0]    d2sat;
      logic [RADIUS_BITS-1:0] radius;
      logic                   rej_proj;
   } side_type;

   typedef logic [31:0] sin_tab_type [0:90];

   function automatic logic [31:0] sin_q30(input int unsigned k);
      longint unsigned x;
      longint unsigned t;
      longint          acc;
      x   = (longint'(k) * PI_Q30 + 64'd90) / 64'd180;
      t   = x;
      acc = longint'(x);
      for (int n = 1; n <= 12; n++) begin
         t = (((t * x) >> 30) * x) >> 30;
         t = t / TAYLOR_DIV[n];
         if ((n % 2) == 1) begin
            acc = acc - longint'(t);
         end else begin
            acc = acc + longint'(t);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      return acc[31:0];
   endfunction

   function automatic sin_tab_type build_sin_tab();
      sin_tab_type tab;
      for (int k = 0; k <= 90; k++) begin
         tab[k] = sin_q30(k);
      end
      return tab;
   endfunction

   localparam sin_tab_type SIN_Q30 = build_sin_tab();

endpackage

`default_nettype wire

// File: sv/cobo_isqrt.sv
//------------------------------------------------------------------------------
// cobo_isqrt
// Pipelined integer square root, one result bit per register stage.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cobo_isqrt
   import cobo_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         advance,
   input  wire logic [2*RAD_ROOT_BITS-1:0]   op_in,
   output logic      [RAD_ROOT_BITS-1:0]     root_out
);

   localparam int R  = RAD_ROOT_BITS;
   localparam int OW = 2 * R;
   localparam int RW = R + 3;

   logic [RW-1:0] rem_ff  [R];
   logic [R-1:0]  root_ff [R];
   logic [OW-1:0] op_ff   [R];

   for (genvar j = 0; j < R; j++) begin : g_stage
      logic [RW-1:0] rem_src;
      logic [R-1:0]  root_src;
      logic [OW-1:0] op_src;
      logic [RW-1:0] cur;
      logic [RW-1:0] trial;
      logic [RW-1:0] rem_in;
      logic [R-1:0]  root_in;
      logic [OW-1:0] op_in_nxt;

      if (j == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign op_src   = op_in;
      end else begin : g_next
         assign rem_src  = rem_ff[j-1];
         assign root_src = root_ff[j-1];
         assign op_src   = op_ff[j-1];
      end

      always_comb begin
         cur       = {rem_src[RW-3:0], op_src[OW-1:OW-2]};
         trial     = RW'({root_src, 2'b01});
         op_in_nxt = op_src << 2;
         if (cur >= trial) begin
            rem_in  = cur - trial;
            root_in = {root_src[R-2:0], 1'b1};
         end else begin
            rem_in  = cur;
            root_in = {root_src[R-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            op_ff[j]   <= op_in_nxt;
         end
      end
   end

   assign root_out = root_ff[R-1];

endmodule

`default_nettype wire

// File: sv/circle_obb_overlap_test.sv
//------------------------------------------------------------------------------
// circle_obb_overlap_test
// Circle versus oriented rectangle overlap test: projection of the circle
// center on both rectangle axes, then a bounding-circle reject.
//------------------------------------------------------------------------------
// Throughput: one pair per cycle unless the result stalls; the half-diagonal root pipeline sets depth.
// A stalled result holds the whole pipeline in place.
// Reset clears the valid bits only; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module circle_obb_overlap_test
   import cobo_pkg::*;
#(
   parameter int COORD_BITS     = DEF_COORD_BITS,
   parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [COORD_BITS-1:0]  req_rect_center_x,
   input  wire logic signed [COORD_BITS-1:0]  req_rect_center_y,
   input  wire logic [ANGLE_BITS-1:0]         req_angle_deg,
   input  wire logic [SIDE_BITS-1:0]          req_rect_length,
   input  wire logic [SIDE_BITS-1:0]          req_rect_width,
   input  wire logic signed [COORD_BITS-1:0]  req_circle_center_x,
   input  wire logic signed [COORD_BITS-1:0]  req_circle_center_y,
   input  wire logic [RADIUS_BITS-1:0]        req_circle_radius,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_hit
);

   localparam int CB   = COORD_BITS;
   localparam int F    = TRIG_FRAC_BITS;
   localparam int S    = F + 1;
   localparam int DXW  = CB + 1;
   localparam int D2W  = 2 * DXW;
   localparam int D2X  = (D2W > SAT_BITS) ? D2W : SAT_BITS;
   localparam int MAGW = F + 2;
   localparam int SW   = F + 3;
   localparam int PW   = SW + SIDE_BITS + 1;
   localparam int RXW  = CB + S;
   localparam int VW   = ((RXW > PW) ? RXW : PW) + 1;
   localparam int MW   = EXT_BITS + DXW;
   localparam int DW   = MW + 1;

   logic                  advance;
   logic [PIPE_DEPTH-1:0] vld_ff;

   assign advance   = !(vld_ff[PIPE_DEPTH-1] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = vld_ff[PIPE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   function automatic quad_type quad_map(input logic [ANGLE_BITS-1:0] a);
      quad_type q;
      logic [9:0] aw;
      aw = 10'(a);
      if (aw <= DEG_QUARTER) begin
         q.idx = TRIG_IDX_BITS'(aw);
         q.neg = 1'b0;
      end else if (aw <= DEG_HALF_TURN) begin
         q.idx = TRIG_IDX_BITS'(DEG_HALF_TURN - aw);
         q.neg = 1'b0;
      end else if (aw <= DEG_THREE_QTR) begin
         q.idx = TRIG_IDX_BITS'(aw - DEG_HALF_TURN);
         q.neg = 1'b1;
      end else begin
         q.idx = TRIG_IDX_BITS'(DEG_FULL_TURN - aw);
         q.neg = 1'b1;
      end
      return q;
   endfunction

   function automatic logic signed [SW-1:0] trig_val(input quad_type q);
      logic [32:0]     sum;
      logic [MAGW-1:0] mag;
      logic signed [SW-1:0] m;
      sum = 33'(SIN_Q30[q.idx]) + (33'd1 << (29 - F));
      mag = MAGW'(sum >> (30 - F));
      m   = signed'({1'b0, mag});
      return q.neg ? -m : m;
   endfunction

   function automatic logic signed [EXT_BITS-1:0] trunc_off(
      input logic signed [VW-1:0] v,
      input logic signed [CB-1:0] c
   );
      logic signed [VW-1:0] vb;
      logic signed [VW-1:0] t;
      vb = v + (v[VW-1] ? VW'((64'd1 << S) - 64'd1) : VW'(0));
      t  = vb >>> S;
      return EXT_BITS'(t - VW'(c));
   endfunction

   // stage 1
   logic signed [DXW-1:0]  dx_s1_ff, dy_s1_ff;
   logic [HALF_BITS-1:0]   hl_s1_ff, hw_s1_ff;
   logic [RADIUS_BITS-1:0] r_s1_ff;
   logic [SIDE_BITS-1:0]   len_s1_ff, wid_s1_ff;
   logic signed [CB-1:0]   rcx_s1_ff, rcy_s1_ff;
   quad_type               sq_s1_ff, cq_s1_ff;
   logic [HH_BITS-1:0]     hh_s1_ff;

   logic [ANGLE_BITS-1:0]  amod_in, bmod_in;
   logic [9:0]             bsum;
   logic [HALF_BITS-1:0]   hl_in, hw_in;

   always_comb begin
      amod_in = (10'(req_angle_deg) >= DEG_FULL_TURN) ?
                ANGLE_BITS'(10'(req_angle_deg) - DEG_FULL_TURN) : req_angle_deg;
      bsum    = 10'(amod_in) + DEG_QUARTER;
      bmod_in = (bsum >= DEG_FULL_TURN) ? ANGLE_BITS'(bsum - DEG_FULL_TURN)
                                        : ANGLE_BITS'(bsum);
      hl_in   = req_rect_length[SIDE_BITS-1:1];
      hw_in   = req_rect_width[SIDE_BITS-1:1];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_s1_ff  <= DXW'(req_circle_center_x) - DXW'(req_rect_center_x);
         dy_s1_ff  <= DXW'(req_circle_center_y) - DXW'(req_rect_center_y);
         hl_s1_ff  <= hl_in;
         hw_s1_ff  <= hw_in;
         r_s1_ff   <= req_circle_radius;
         len_s1_ff <= req_rect_length;
         wid_s1_ff <= req_rect_width;
         rcx_s1_ff <= req_rect_center_x;
         rcy_s1_ff <= req_rect_center_y;
         sq_s1_ff  <= quad_map(amod_in);
         cq_s1_ff  <= quad_map(bmod_in);
         hh_s1_ff  <= HH_BITS'(HH_BITS'(hl_in) * HH_BITS'(hl_in))
                    + HH_BITS'(HH_BITS'(hw_in) * HH_BITS'(hw_in));
      end
   end

   // stage 2
   logic signed [DXW-1:0]  dx_s2_ff, dy_s2_ff;
   logic [HALF_BITS-1:0]   hl_s2_ff, hw_s2_ff;
   logic [RADIUS_BITS-1:0] r_s2_ff;
   logic [SIDE_BITS-1:0]   len_s2_ff, wid_s2_ff;
   logic signed [CB-1:0]   rcx_s2_ff, rcy_s2_ff;
   logic signed [SW-1:0]   sn_s2_ff, cs_s2_ff;
   logic [D2W-1:0]         d2_s2_ff;

   logic signed [D2W-1:0]  sqx, sqy;

   always_comb begin
      sqx = dx_s1_ff * dx_s1_ff;
      sqy = dy_s1_ff * dy_s1_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_s2_ff  <= dx_s1_ff;
         dy_s2_ff  <= dy_s1_ff;
         hl_s2_ff  <= hl_s1_ff;
         hw_s2_ff  <= hw_s1_ff;
         r_s2_ff   <= r_s1_ff;
         len_s2_ff <= len_s1_ff;
         wid_s2_ff <= wid_s1_ff;
         rcx_s2_ff <= rcx_s1_ff;
         rcy_s2_ff <= rcy_s1_ff;
         sn_s2_ff  <= trig_val(sq_s1_ff);
         cs_s2_ff  <= trig_val(cq_s1_ff);
         d2_s2_ff  <= unsigned'(sqx) + unsigned'(sqy);
      end
   end

   // stage 3
   logic signed [DXW-1:0]  dx_s3_ff, dy_s3_ff;
   logic [HALF_BITS-1:0]   hl_s3_ff, hw_s3_ff;
   logic [RADIUS_BITS-1:0] r_s3_ff;
   logic signed [CB-1:0]   rcx_s3_ff, rcy_s3_ff;
   logic signed [PW-1:0]   plx_s3_ff, ply_s3_ff, pwx_s3_ff, pwy_s3_ff;
   logic [SAT_BITS-1:0]    d2sat_s3_ff;

   logic signed [SIDE_BITS:0] len_sg, wid_sg;
   logic signed [PW-1:0]      plx_in, ply_in, pwx_in, pwy_in;
   logic [D2X-1:0]            d2x;
   logic [SAT_BITS-1:0]       d2sat_in;

   always_comb begin
      len_sg   = signed'({1'b0, len_s2_ff});
      wid_sg   = signed'({1'b0, wid_s2_ff});
      plx_in   = cs_s2_ff * len_sg;
      ply_in   = sn_s2_ff * len_sg;
      pwx_in   = sn_s2_ff * wid_sg;
      pwy_in   = cs_s2_ff * wid_sg;
      d2x      = D2X'(d2_s2_ff);
      d2sat_in = (d2x > D2X'(DIST2_SAT)) ? SAT_BITS'(DIST2_SAT)
                                         : d2x[SAT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_s3_ff    <= dx_s2_ff;
         dy_s3_ff    <= dy_s2_ff;
         hl_s3_ff    <= hl_s2_ff;
         hw_s3_ff    <= hw_s2_ff;
         r_s3_ff     <= r_s2_ff;
         rcx_s3_ff   <= rcx_s2_ff;
         rcy_s3_ff   <= rcy_s2_ff;
         plx_s3_ff   <= plx_in;
         ply_s3_ff   <= ply_in;
         pwx_s3_ff   <= pwx_in;
         pwy_s3_ff   <= pwy_in;
         d2sat_s3_ff <= d2sat_in;
      end
   end

   // stage 4
   logic signed [DXW-1:0]      dx_s4_ff, dy_s4_ff;
   logic [HALF_BITS-1:0]       hl_s4_ff, hw_s4_ff;
   logic [RADIUS_BITS-1:0]     r_s4_ff;
   logic signed [EXT_BITS-1:0] exl_s4_ff, eyl_s4_ff, exw_s4_ff, eyw_s4_ff;
   logic [SAT_BITS-1:0]        d2sat_s4_ff;

   logic signed [VW-1:0] basex, basey;

   always_comb begin
      basex = VW'(rcx_s3_ff) <<< S;
      basey = VW'(rcy_s3_ff) <<< S;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_s4_ff    <= dx_s3_ff;
         dy_s4_ff    <= dy_s3_ff;
         hl_s4_ff    <= hl_s3_ff;
         hw_s4_ff    <= hw_s3_ff;
         r_s4_ff     <= r_s3_ff;
         exl_s4_ff   <= trunc_off(basex + VW'(plx_s3_ff), rcx_s3_ff);
         eyl_s4_ff   <= trunc_off(basey - VW'(ply_s3_ff), rcy_s3_ff);
         exw_s4_ff   <= trunc_off(basex - VW'(pwx_s3_ff), rcx_s3_ff);
         eyw_s4_ff   <= trunc_off(basey - VW'(pwy_s3_ff), rcy_s3_ff);
         d2sat_s4_ff <= d2sat_s3_ff;
      end
   end

   // stage 5
   logic [HALF_BITS-1:0]   hl_s5_ff, hw_s5_ff;
   logic [RADIUS_BITS-1:0] r_s5_ff;
   logic signed [MW-1:0]   mlx_s5_ff, mly_s5_ff, mwx_s5_ff, mwy_s5_ff;
   logic [BOUND_BITS-1:0]  bl_s5_ff, bw_s5_ff;
   logic [SAT_BITS-1:0]    d2sat_s5_ff;

   logic signed [MW-1:0]     mlx_in, mly_in, mwx_in, mwy_in;
   logic [SUM_SIDE_BITS-1:0] sl, sw;

   always_comb begin
      mlx_in = exl_s4_ff * dx_s4_ff;
      mly_in = eyl_s4_ff * dy_s4_ff;
      mwx_in = exw_s4_ff * dx_s4_ff;
      mwy_in = eyw_s4_ff * dy_s4_ff;
      sl     = SUM_SIDE_BITS'(hl_s4_ff) + SUM_SIDE_BITS'(r_s4_ff) + SUM_SIDE_BITS'(1);
      sw     = SUM_SIDE_BITS'(hw_s4_ff) + SUM_SIDE_BITS'(r_s4_ff) + SUM_SIDE_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hl_s5_ff    <= hl_s4_ff;
         hw_s5_ff    <= hw_s4_ff;
         r_s5_ff     <= r_s4_ff;
         mlx_s5_ff   <= mlx_in;
         mly_s5_ff   <= mly_in;
         mwx_s5_ff   <= mwx_in;
         mwy_s5_ff   <= mwy_in;
         bl_s5_ff    <= BOUND_BITS'(sl) * BOUND_BITS'(hl_s4_ff);
         bw_s5_ff    <= BOUND_BITS'(sw) * BOUND_BITS'(hw_s4_ff);
         d2sat_s5_ff <= d2sat_s4_ff;
      end
   end

   // stage 6
   logic [HALF_BITS-1:0]   hl_s6_ff, hw_s6_ff;
   logic [RADIUS_BITS-1:0] r_s6_ff;
   logic [DW-1:0]          al_s6_ff, aw_s6_ff;
   logic [BOUND_BITS-1:0]  bl_s6_ff, bw_s6_ff;
   logic [SAT_BITS-1:0]    d2sat_s6_ff;

   logic signed [DW-1:0] dot_l, dot_w;

   always_comb begin
      dot_l = DW'(mlx_s5_ff) + DW'(mly_s5_ff);
      dot_w = DW'(mwx_s5_ff) + DW'(mwy_s5_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hl_s6_ff    <= hl_s5_ff;
         hw_s6_ff    <= hw_s5_ff;
         r_s6_ff     <= r_s5_ff;
         al_s6_ff    <= dot_l[DW-1] ? unsigned'(-dot_l) : unsigned'(dot_l);
         aw_s6_ff    <= dot_w[DW-1] ? unsigned'(-dot_w) : unsigned'(dot_w);
         bl_s6_ff    <= bl_s5_ff;
         bw_s6_ff    <= bw_s5_ff;
         d2sat_s6_ff <= d2sat_s5_ff;
      end
   end

   // stage 7: axis rejects, |dot|/h > h+r  <=>  |dot| >= (h+r+1)*h
   side_type side_s7_ff;
   side_type side_in;

   always_comb begin
      side_in.d2sat    = d2sat_s6_ff;
      side_in.radius   = r_s6_ff;
      side_in.rej_proj = ((hl_s6_ff != '0) && (al_s6_ff >= DW'(bl_s6_ff)))
                      || ((hw_s6_ff != '0) && (aw_s6_ff >= DW'(bw_s6_ff)));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_s7_ff <= side_in;
      end
   end

   // stages 8 to 19: hold side data while the half-diagonal root settles
   side_type dly_ff [DLY_DEPTH];

   always_ff @(posedge clock) begin
      if (advance) begin
         dly_ff[0] <= side_s7_ff;
         for (int i = 1; i < DLY_DEPTH; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   logic [RAD_ROOT_BITS-1:0] rad_root;

   cobo_isqrt u_isqrt (
      .clock    (clock),
      .advance  (advance),
      .op_in    ({hh_s1_ff, DIST_FRAC_SHIFT'(0)}),
      .root_out (rad_root)
   );

   // stage 20
   side_type             side_s20_ff;
   logic [KP1_BITS-1:0]  kp1_s20_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         side_s20_ff <= dly_ff[DLY_DEPTH-1];
         kp1_s20_ff  <= KP1_BITS'(rad_root)
                      + KP1_BITS'({dly_ff[DLY_DEPTH-1].radius, RADIUS_SHIFT'(0)})
                      + KP1_BITS'(1);
      end
   end

   // stage 21
   side_type              side_s21_ff;
   logic [2*KP1_BITS-1:0] sq_s21_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         side_s21_ff <= side_s20_ff;
         sq_s21_ff   <= (2*KP1_BITS)'(kp1_s20_ff) * (2*KP1_BITS)'(kp1_s20_ff);
      end
   end

   // stage 22: bounding reject when dist^2 << 16 >= (rad + r<<8 + 1)^2
   logic hit_ff;
   logic rej_bound;

   always_comb begin
      rej_bound = {side_s21_ff.d2sat, DIST_FRAC_SHIFT'(0)} >= AREA_BITS'(sq_s21_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hit_ff <= !rej_bound && !side_s21_ff.rej_proj;
      end
   end

   assign rsp_hit = hit_ff;

endmodule

`default_nettype wire

// File: sv/cobo_checker.sv
//------------------------------------------------------------------------------
// cobo_checker
// Port-level checks for the overlap test, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cobo_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_hit
);

   a_reset_empties : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_source : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result");

   a_result_holds : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_hit)))
      else $error("stalled result changed");

   a_drain : assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while result side is free");

endmodule

bind circle_obb_overlap_test cobo_checker u_cobo_checker (.*);

`default_nettype wire
